/* rtl/nsss_pkg.sv */
// ----------------------------------------------------------------------------
// nsss_pkg: shared types and constants for the node/segment snap search
// Item kinds, result kinds and datapath widths used by the top level and
// by the fraction divider.
// ----------------------------------------------------------------------------
package nsss_pkg;

  localparam int FIELD_W  = 24;   // coordinate field width on the ports
  localparam int SLOT_W   = 8;    // slot index field width
  localparam int GEN_W    = 16;   // generation field width
  localparam int FRAC_W   = 32;   // internal segment parameter bits
  localparam int PROD_W   = 52;   // width of dot and len2 sums
  localparam int IN_W     = 96;   // s_tdata width
  localparam int OUT_W    = 88;   // m_tdata width

  localparam int DEF_NODE_SLOTS    = 256;
  localparam int DEF_SEGMENT_SLOTS = 256;
  localparam int DEF_COORD_BITS    = 24;

  typedef enum logic [1:0] {
    KIND_NODE  = 2'd0,
    KIND_SEG   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } item_kind_t;

  typedef enum logic [1:0] {
    RES_FREE = 2'd0,
    RES_NODE = 2'd1,
    RES_SEG  = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    REG_NODE_RADIUS = 2'd0,
    REG_SNAP_SEG    = 2'd1,
    REG_SEG_RADIUS  = 2'd2,
    REG_MIN_SPLIT   = 2'd3
  } reg_index_t;

endpackage

/* rtl/nsss_div.sv */
// ----------------------------------------------------------------------------
// nsss_div: restoring fraction divider
// Computes floor(num * 2^FRAC_W / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module nsss_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nsss_pkg::PROD_W-1:0] num,
  input  logic [nsss_pkg::PROD_W-1:0] den,
  output logic                       done,
  output logic [nsss_pkg::FRAC_W-1:0] quo
);
  import nsss_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [PROD_W:0]   rem;
  logic [PROD_W:0]   rem_sh;
  logic [PROD_W:0]   den_q;
  logic [CNT_W-1:0]  cnt;
  logic              run;

  assign rem_sh = {rem[PROD_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(FRAC_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_q <= {1'b0, den};
      quo   <= '0;
    end else if (run) begin
      if (rem_sh >= den_q) begin
        rem <= rem_sh - den_q;
        quo <= {quo[FRAC_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[FRAC_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/node_segment_snap_search.sv */
// ----------------------------------------------------------------------------
// node_segment_snap_search: snap a 2-D cursor to a node or a segment interior
// Node and segment tables live in synchronous RAMs loaded by items; a query
// scans them through a one-step-at-a-time sequencer and returns one item.
// ----------------------------------------------------------------------------
// After reset the block clears the live flags of every slot in the table RAMs;
// s_tready stays low until that is done. Load items (node or segment) give no
// result. A query first scans every node slot when node_radius is nonzero, in
// the steps RAM read, difference, square and compare. Then, if no node was hit
// and segment snapping is on with a nonzero segment_radius, it scans every
// segment slot: a dead segment or one with an end slot out of range is dropped
// after the segment read, one with a dead end node after the end-node read,
// one whose projection falls outside the segment after the products and sums,
// and a candidate goes through the 32-step bit-serial divider that forms the
// segment parameter and then the projection, distance and compare steps. A
// query waits for a still pending result to leave before it hands over its
// own. The result item sits in an output register; the next input item is
// accepted while it waits. Ties on distance go to the later slot. seg_t is the
// top 16 bits of the 32-bit segment parameter.
module node_segment_snap_search #(
  parameter int NODE_SLOTS    = nsss_pkg::DEF_NODE_SLOTS,
  parameter int SEGMENT_SLOTS = nsss_pkg::DEF_SEGMENT_SLOTS,
  parameter int COORD_BITS    = nsss_pkg::DEF_COORD_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  // s_tdata: entry_index[7:0], pos_x[31:8], pos_y[55:32], entry_alive[56],
  //          entry_generation[72:57], end_a_index[80:73], end_b_index[88:81]
  input  logic [nsss_pkg::IN_W-1:0]  s_tdata,
  input  logic [1:0]                 s_tuser,   // kind[1:0]
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // m_tdata: hit_index[7:0], hit_generation[23:8], out_x[47:24],
  //          out_y[71:48], seg_t[87:72]
  output logic [nsss_pkg::OUT_W-1:0] m_tdata,
  output logic [1:0]                 m_tuser,   // result_kind[1:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [23:0]                cfg_data
);
  import nsss_pkg::*;

  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int SH = FIELD_W - CW;
  localparam int NA = $clog2(NODE_SLOTS);
  localparam int SA = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
  localparam int BW = 56;   // squared distance width
  localparam int CLR_N = (NODE_SLOTS > SEGMENT_SLOTS) ? NODE_SLOTS : SEGMENT_SLOTS;
  localparam int CA = $clog2(CLR_N);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_N_RD, ST_N_DIFF, ST_N_SQ, ST_N_CMP,
    ST_S_RD, ST_S_ENDS, ST_S_DIFF, ST_S_MUL, ST_S_SUM, ST_S_CHK, ST_S_DIV,
    ST_S_PROJ, ST_S_PT, ST_S_D, ST_S_SQ, ST_S_CMP, ST_DONE
  } state_t;

  state_t state;

  // config registers
  logic [23:0] node_radius, segment_radius, min_split;
  logic        snap_seg;

  // input fields
  logic [1:0]         in_kind;
  logic [31:0]        in_idx;
  logic signed [23:0] in_x, in_y;
  logic [23:0]        sh_x, sh_y;
  logic               in_alive;
  logic [15:0]        in_gen;
  logic [SLOT_W-1:0]  in_a, in_b;
  logic               accept;

  assign in_kind  = s_tuser;
  assign in_idx   = {24'd0, s_tdata[7:0]};
  assign sh_x     = s_tdata[31:8] << SH;
  assign sh_y     = s_tdata[55:32] << SH;
  assign in_x     = $signed(sh_x) >>> SH;
  assign in_y     = $signed(sh_y) >>> SH;
  assign in_alive = s_tdata[56];
  assign in_gen   = s_tdata[72:57];
  assign in_a     = s_tdata[80:73];
  assign in_b     = s_tdata[88:81];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // ---------------- node and segment RAMs ----------------
  logic signed [23:0] nx_mem [NODE_SLOTS];
  logic signed [23:0] ny_mem [NODE_SLOTS];
  logic [15:0]        ng_mem [NODE_SLOTS];
  logic               nl_mem [NODE_SLOTS];
  logic [SLOT_W-1:0]  sa_mem [SEGMENT_SLOTS];
  logic [SLOT_W-1:0]  sb_mem [SEGMENT_SLOTS];
  logic [15:0]        sg_mem [SEGMENT_SLOTS];
  logic               sl_mem [SEGMENT_SLOTS];

  logic node_wr, seg_wr;
  logic [NA-1:0] waddr_n, addr_a, addr_b;
  logic [SA-1:0] waddr_s, nidx_s;
  logic [NA-1:0] nidx;
  logic [SA-1:0] sidx;
  logic signed [23:0] nxa_q, nya_q, nxb_q, nyb_q;
  logic [15:0]        nga_q, sg_q;
  logic [SLOT_W-1:0]  sa_q, sb_q;
  logic [31:0]        sa_ext, sb_ext;
  logic               nla_q, nlb_q, sl_q;
  logic [CA-1:0]      clr_idx;
  logic               clr_n, clr_s, clr_last;

  assign node_wr = accept && (in_kind == KIND_NODE) && (in_idx < NODE_SLOTS);
  assign seg_wr  = accept && (in_kind == KIND_SEG) && (in_idx < SEGMENT_SLOTS);
  assign waddr_n = in_idx[NA-1:0];
  assign waddr_s = in_idx[SA-1:0];
  assign sa_ext  = {24'd0, sa_q};
  assign sb_ext  = {24'd0, sb_q};
  assign nidx_s  = sidx;

  // live-flag clearing pass after reset
  assign clr_n    = (state == ST_CLR) && (int'(clr_idx) < NODE_SLOTS);
  assign clr_s    = (state == ST_CLR) && (int'(clr_idx) < SEGMENT_SLOTS);
  assign clr_last = (clr_idx == CA'(CLR_N - 1));

  always_comb begin
    if (state == ST_S_ENDS) begin
      addr_a = sa_ext[NA-1:0];
      addr_b = sb_ext[NA-1:0];
    end else begin
      addr_a = nidx;
      addr_b = nidx;
    end
  end

  always_ff @(posedge clk) begin
    if (node_wr) begin
      nx_mem[waddr_n] <= in_x;
      ny_mem[waddr_n] <= in_y;
      ng_mem[waddr_n] <= in_gen;
    end
    nxa_q <= nx_mem[addr_a];
    nya_q <= ny_mem[addr_a];
    nga_q <= ng_mem[addr_a];
    nxb_q <= nx_mem[addr_b];
    nyb_q <= ny_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (seg_wr) begin
      sa_mem[waddr_s] <= in_a;
      sb_mem[waddr_s] <= in_b;
      sg_mem[waddr_s] <= in_gen;
    end
    sa_q <= sa_mem[nidx_s];
    sb_q <= sb_mem[nidx_s];
    sg_q <= sg_mem[nidx_s];
  end

  always_ff @(posedge clk) begin
    if (node_wr)    nl_mem[waddr_n] <= in_alive;
    else if (clr_n) nl_mem[clr_idx[NA-1:0]] <= 1'b0;
    if (seg_wr)     sl_mem[waddr_s] <= in_alive;
    else if (clr_s) sl_mem[clr_idx[SA-1:0]] <= 1'b0;
    nla_q <= nl_mem[addr_a];
    nlb_q <= nl_mem[addr_b];
    sl_q  <= sl_mem[nidx_s];
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      node_radius    <= '0;
      snap_seg       <= 1'b1;
      segment_radius <= '0;
      min_split      <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_NODE_RADIUS: node_radius    <= cfg_data;
        REG_SNAP_SEG:    snap_seg       <= cfg_data[0];
        REG_SEG_RADIUS:  segment_radius <= cfg_data;
        REG_MIN_SPLIT:   min_split      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  logic signed [23:0] cur_x, cur_y, ax, ay, bx, by;
  logic [15:0]        cand_gen;
  logic               cand_live;
  logic signed [24:0] ex, ey, dx, dy;
  logic signed [49:0] p1, p2, p3, p4;
  logic [PROD_W-1:0]  len2;
  logic signed [PROD_W-1:0] dot;
  logic signed [57:0] mx, my, mx_r, my_r;
  logic signed [25:0] qx, qy;
  logic signed [26:0] d0x, d0y, d1x, d1y, d2x, d2y;
  logic [53:0]        s0x, s0y, s1x, s1y, s2x, s2y;
  logic [BW-1:0]      best, m2, dn, d0, d1, d2;
  logic [47:0]        nrad_sq, srad_sq, split_sq;
  logic [FRAC_W-1:0]  quo, q_r;
  logic               div_start, div_done;
  logic               seg_on, nlast, slast;

  logic [1:0]         res_kind;
  logic [7:0]         res_idx;
  logic [15:0]        res_gen, res_t;
  logic [23:0]        res_x, res_y;

  assign seg_on = snap_seg && (segment_radius != '0);
  assign nlast  = (nidx == NA'(NODE_SLOTS - 1));
  assign slast  = (sidx == SA'(SEGMENT_SLOTS - 1));
  assign div_start = (state == ST_S_CHK) && (dot > 0) && ($unsigned(dot) < len2);

  assign nrad_sq  = node_radius * node_radius;
  assign srad_sq  = segment_radius * segment_radius;
  assign split_sq = min_split * min_split;

  assign mx = ex * $signed({1'b0, q_r});
  assign my = ey * $signed({1'b0, q_r});
  assign dn = BW'($unsigned(p1)) + BW'($unsigned(p2));
  assign d0 = BW'(s0x) + BW'(s0y);
  assign d1 = BW'(s1x) + BW'(s1y);
  assign d2 = BW'(s2x) + BW'(s2y);

  nsss_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ($unsigned(dot)),
    .den   (len2),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      m_tvalid <= 1'b0;
      nidx     <= '0;
      sidx     <= '0;
      clr_idx  <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept && in_kind == KIND_QUERY) begin
            cur_x    <= in_x;
            cur_y    <= in_y;
            res_kind <= RES_FREE;
            res_idx  <= '0;
            res_gen  <= '0;
            res_t    <= '0;
            res_x    <= in_x;
            res_y    <= in_y;
            m2       <= BW'(split_sq);
            nidx     <= '0;
            sidx     <= '0;
            if (node_radius != '0) begin
              best  <= BW'(nrad_sq);
              state <= ST_N_RD;
            end else if (seg_on) begin
              best  <= BW'(srad_sq);
              state <= ST_S_RD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_N_RD: state <= ST_N_DIFF;
        ST_N_DIFF: begin
          ax        <= nxa_q;
          ay        <= nya_q;
          cand_gen  <= nga_q;
          cand_live <= nla_q;
          dx        <= 25'(nxa_q) - 25'(cur_x);
          dy        <= 25'(nya_q) - 25'(cur_y);
          state     <= ST_N_SQ;
          if (!nla_q) begin
            state <= ST_N_CMP;
            dx    <= '0;
            dy    <= '0;
          end
        end
        ST_N_SQ: begin
          p1    <= dx * dx;
          p2    <= dy * dy;
          state <= ST_N_CMP;
        end
        ST_N_CMP: begin
          if (cand_live && dn <= best) begin
            best     <= dn;
            res_kind <= RES_NODE;
            res_idx  <= 8'(nidx);
            res_gen  <= cand_gen;
            res_x    <= ax;
            res_y    <= ay;
          end
          if (!nlast) begin
            nidx  <= nidx + 1'b1;
            state <= ST_N_RD;
          end else if ((res_kind == RES_FREE) && !(cand_live && dn <= best)
                       && seg_on) begin
            best  <= BW'(srad_sq);
            state <= ST_S_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_S_RD: state <= ST_S_ENDS;
        ST_S_ENDS: begin
          cand_gen <= sg_q;
          // end nodes are read this cycle; their live flags arrive next cycle
          if (sl_q && sa_ext < NODE_SLOTS && sb_ext < NODE_SLOTS) begin
            state <= ST_S_DIFF;
          end else if (!slast) begin
            sidx  <= sidx + 1'b1;
            state <= ST_S_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_S_DIFF: begin
          ax    <= nxa_q;
          ay    <= nya_q;
          bx    <= nxb_q;
          by    <= nyb_q;
          ex    <= 25'(nxb_q) - 25'(nxa_q);
          ey    <= 25'(nyb_q) - 25'(nya_q);
          dx    <= 25'(cur_x) - 25'(nxa_q);
          dy    <= 25'(cur_y) - 25'(nya_q);
          if (nla_q && nlb_q) begin
            state <= ST_S_MUL;
          end else if (!slast) begin
            sidx  <= sidx + 1'b1;
            state <= ST_S_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_S_MUL: begin
          p1    <= ex * ex;
          p2    <= ey * ey;
          p3    <= ex * dx;
          p4    <= ey * dy;
          state <= ST_S_SUM;
        end
        ST_S_SUM: begin
          len2  <= PROD_W'($unsigned(p1)) + PROD_W'($unsigned(p2));
          dot   <= PROD_W'(p3) + PROD_W'(p4);
          state <= ST_S_CHK;
        end
        ST_S_CHK: begin
          if (div_start) begin
            state <= ST_S_DIV;
          end else if (!slast) begin
            sidx  <= sidx + 1'b1;
            state <= ST_S_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_S_DIV: begin
          if (div_done) begin
            q_r   <= quo;
            state <= ST_S_PROJ;
          end
        end
        ST_S_PROJ: begin
          mx_r  <= mx + 58'sd2147483648;
          my_r  <= my + 58'sd2147483648;
          state <= ST_S_PT;
        end
        ST_S_PT: begin
          qx    <= 26'(ax) + 26'(mx_r >>> FRAC_W);
          qy    <= 26'(ay) + 26'(my_r >>> FRAC_W);
          state <= ST_S_D;
        end
        ST_S_D: begin
          d0x   <= 27'(qx) - 27'(cur_x);
          d0y   <= 27'(qy) - 27'(cur_y);
          d1x   <= 27'(qx) - 27'(ax);
          d1y   <= 27'(qy) - 27'(ay);
          d2x   <= 27'(qx) - 27'(bx);
          d2y   <= 27'(qy) - 27'(by);
          state <= ST_S_SQ;
        end
        ST_S_SQ: begin
          s0x   <= d0x * d0x;
          s0y   <= d0y * d0y;
          s1x   <= d1x * d1x;
          s1y   <= d1y * d1y;
          s2x   <= d2x * d2x;
          s2y   <= d2y * d2y;
          state <= ST_S_CMP;
        end
        ST_S_CMP: begin
          if (d0 <= best && d1 >= m2 && d2 >= m2) begin
            best     <= d0;
            res_kind <= RES_SEG;
            res_idx  <= 8'(sidx);
            res_gen  <= cand_gen;
            res_x    <= qx[23:0];
            res_y    <= qy[23:0];
            res_t    <= q_r[FRAC_W-1 -: 16];
          end
          if (!slast) begin
            sidx  <= sidx + 1'b1;
            state <= ST_S_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_kind;
            m_tdata  <= {res_t, res_y, res_x, res_gen, res_idx};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
